/* hdl/xys_pkg.sv */
// ----------------------------------------------------------------------------
// xys_pkg
// Shared types and constants for the XY scope image scanner.
// ----------------------------------------------------------------------------
package xys_pkg;

    localparam int ACTION_W   = 3;
    localparam int PADDR_W    = 13;
    localparam int PIXEL_W    = 8;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int ZOOM_W     = 2;

    localparam int IMAGE_WIDTH_DEF  = 80;
    localparam int IMAGE_HEIGHT_DEF = 80;
    localparam int MAX_ZOOM_DEF     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PRESENT = 1'b1;

    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd200;

    // reciprocal scaling: floor(d*2^16/span) == (d*ceil(2^30/span)) >> 14
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 30;

    localparam int                  SAT_LIMIT   = 65535;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 16'h8000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK     = 3'd0,
        ACT_LOAD     = 3'd1,
        ACT_ZOOM_IN  = 3'd2,
        ACT_ZOOM_OUT = 3'd3,
        ACT_UP       = 3'd4,
        ACT_LEFT     = 3'd5,
        ACT_DOWN     = 3'd6,
        ACT_RIGHT    = 3'd7
    } action_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } state_t;

endpackage

/* hdl/xys_if.sv */
// ----------------------------------------------------------------------------
// xys_cmd_if / xys_smp_if
// Valid/ready channels: command words in, sample words out.
// ----------------------------------------------------------------------------
interface xys_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [xys_pkg::ACTION_W-1:0]  action;
    logic [xys_pkg::PADDR_W-1:0]   pixel_addr;
    logic [xys_pkg::PIXEL_W-1:0]   pixel_value;

    modport source (output valid, output action, output pixel_addr, output pixel_value,
                    input ready);
    modport sink   (input valid, input action, input pixel_addr, input pixel_value,
                    output ready);
endinterface

interface xys_smp_if;
    logic                                valid;
    logic                                ready;
    logic signed [xys_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [xys_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* hdl/xys_ram.sv */
// ----------------------------------------------------------------------------
// xys_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module xys_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/xys_norm.sv */
// ----------------------------------------------------------------------------
// xys_norm
// Scan offset inside the window to signed Q1.15, saturating at +1.
// ----------------------------------------------------------------------------
module xys_norm #(
    parameter int CRD_W = 8,
    parameter int WIN_W = 7
) (
    input  logic [CRD_W-1:0]               pos,
    input  logic [WIN_W-1:0]               win,
    input  logic [xys_pkg::RECIP_W-1:0]    recip,
    output logic [xys_pkg::SAMPLE_W-1:0]   sample
);

    localparam int PROD_W = CRD_W + xys_pkg::RECIP_W;
    localparam int Q_LO   = xys_pkg::RECIP_SHIFT - xys_pkg::SAMPLE_W;
    localparam int Q_W    = PROD_W - Q_LO;

    logic [CRD_W-1:0]  win_e;
    logic [CRD_W-1:0]  offs;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    quot;

    assign win_e = CRD_W'(win);
    assign offs  = (pos > win_e) ? pos - win_e : '0;
    assign prod  = PROD_W'(offs) * PROD_W'(recip);
    assign quot  = prod[PROD_W-1:Q_LO];

    assign sample = (quot >= Q_W'(xys_pkg::SAT_LIMIT)) ? xys_pkg::SAMPLE_MAX
                  : quot[xys_pkg::SAMPLE_W-1:0] ^ xys_pkg::SAMPLE_BIAS;

endmodule

/* hdl/xy_scope_image_scanner_core.sv */
// Output: an accepted tick word loads the held deflection into the output register, shown in the next cycle.
// A tick runs the image RAM read, then the threshold and reciprocal multiply in the update state,
// during which no command is taken; load, zoom and pan words need no update state.
// Reset (rst_n low, asynchronous): scan and window at the origin, zoom 1, held samples 0,
// threshold 200, no image. The image RAM is not cleared.
// ----------------------------------------------------------------------------
// xy_scope_image_scanner_core
// Boustrophedon scan of a stored grayscale image for XY deflection output.
// ----------------------------------------------------------------------------
module xy_scope_image_scanner_core #(
    parameter int IMAGE_WIDTH  = xys_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = xys_pkg::IMAGE_HEIGHT_DEF,
    parameter int MAX_ZOOM     = xys_pkg::MAX_ZOOM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [xys_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xys_pkg::CFG_DATA_W-1:0]  cfg_data,
    xys_cmd_if.sink                         command,
    xys_smp_if.source                       sample
);

    localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int WIN_W   = $clog2(DIM_MAX);
    localparam int CRD_W   = $clog2(2 * DIM_MAX);
    localparam int STEP_W  = CRD_W + 1;
    localparam int DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int RAM_AW  = $clog2(DEPTH);
    localparam int LIN_W   = 2 * STEP_W + xys_pkg::PADDR_W;

    localparam int SPAN_X1 = IMAGE_WIDTH;
    localparam int SPAN_X2 = IMAGE_WIDTH / 2;
    localparam int SPAN_X3 = IMAGE_WIDTH / 3;
    localparam int SPAN_Y1 = IMAGE_HEIGHT;
    localparam int SPAN_Y2 = IMAGE_HEIGHT / 2;
    localparam int SPAN_Y3 = IMAGE_HEIGHT / 3;

    localparam logic [63:0] ONE_SH   = 64'd1 << xys_pkg::RECIP_SHIFT;
    localparam logic [63:0] RECIP_X1 = (ONE_SH + SPAN_X1 - 1) / SPAN_X1;
    localparam logic [63:0] RECIP_X2 = (ONE_SH + SPAN_X2 - 1) / SPAN_X2;
    localparam logic [63:0] RECIP_X3 = (ONE_SH + SPAN_X3 - 1) / SPAN_X3;
    localparam logic [63:0] RECIP_Y1 = (ONE_SH + SPAN_Y1 - 1) / SPAN_Y1;
    localparam logic [63:0] RECIP_Y2 = (ONE_SH + SPAN_Y2 - 1) / SPAN_Y2;
    localparam logic [63:0] RECIP_Y3 = (ONE_SH + SPAN_Y3 - 1) / SPAN_Y3;

    xys_pkg::state_t state_reg, state_next;

    logic [xys_pkg::PIXEL_W-1:0]  thr_reg;
    logic                         present_reg;
    logic [CRD_W-1:0]             scan_x_reg, scan_x_next;
    logic [CRD_W-1:0]             scan_y_reg, scan_y_next;
    logic                         rightward_reg, rightward_next;
    logic [xys_pkg::ZOOM_W-1:0]   zoom_reg, zoom_next;
    logic [WIN_W-1:0]             win_x_reg, win_x_next;
    logic [WIN_W-1:0]             win_y_reg, win_y_next;
    logic [xys_pkg::SAMPLE_W-1:0] held_x_reg, held_x_next;
    logic [xys_pkg::SAMPLE_W-1:0] held_y_reg, held_y_next;
    logic                         in_image_reg, in_image_next;
    logic                         out_valid_reg, out_valid_next;
    logic [xys_pkg::SAMPLE_W-1:0] out_left_reg, out_left_next;
    logic [xys_pkg::SAMPLE_W-1:0] out_right_reg, out_right_next;

    xys_pkg::action_t             act;
    logic                         idle;
    logic                         upd_en;
    logic                         accept;
    logic                         tick_acc;

    logic [STEP_W-1:0]            span_x, span_y;
    logic [xys_pkg::RECIP_W-1:0]  recip_x, recip_y;

    logic                         ram_we;
    logic [RAM_AW-1:0]            ram_waddr;
    logic [RAM_AW-1:0]            ram_raddr;
    logic [xys_pkg::PIXEL_W-1:0]  ram_rdata;
    logic [LIN_W-1:0]             load_lin;
    logic [LIN_W-1:0]             read_lin;
    logic [STEP_W-1:0]            nx, ny;

    logic [xys_pkg::PIXEL_W-1:0]  pix;
    logic [xys_pkg::SAMPLE_W-1:0] norm_x, norm_y;

    assign act      = xys_pkg::action_t'(command.action);
    assign command.ready = idle && (!out_valid_reg || sample.ready || act != xys_pkg::ACT_TICK);
    assign accept   = command.valid && command.ready;
    assign tick_acc = accept && (act == xys_pkg::ACT_TICK);

    // spans and reciprocals per zoom level
    always_comb
    begin
        case (zoom_reg)
            2'd2:
            begin
                span_x  = STEP_W'(SPAN_X2);
                span_y  = STEP_W'(SPAN_Y2);
                recip_x = RECIP_X2[xys_pkg::RECIP_W-1:0];
                recip_y = RECIP_Y2[xys_pkg::RECIP_W-1:0];
            end
            2'd3:
            begin
                span_x  = STEP_W'(SPAN_X3);
                span_y  = STEP_W'(SPAN_Y3);
                recip_x = RECIP_X3[xys_pkg::RECIP_W-1:0];
                recip_y = RECIP_Y3[xys_pkg::RECIP_W-1:0];
            end
            default:
            begin
                span_x  = STEP_W'(SPAN_X1);
                span_y  = STEP_W'(SPAN_Y1);
                recip_x = RECIP_X1[xys_pkg::RECIP_W-1:0];
                recip_y = RECIP_Y1[xys_pkg::RECIP_W-1:0];
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xys_pkg::S_IDLE:
            begin
                if (tick_acc)
                begin
                    state_next = xys_pkg::S_UPDATE;
                end
            end
            xys_pkg::S_UPDATE:
            begin
                state_next = xys_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        idle   = 1'b0;
        upd_en = 1'b0;
        unique case (state_reg)
            xys_pkg::S_IDLE:   idle   = 1'b1;
            xys_pkg::S_UPDATE: upd_en = 1'b1;
        endcase
    end

    // scan step for a tick
    always_comb
    begin
        logic [STEP_W-1:0] sx;
        logic [STEP_W-1:0] sy;
        logic [STEP_W-1:0] wx;
        logic [STEP_W-1:0] wy;
        sx = STEP_W'(scan_x_reg);
        sy = STEP_W'(scan_y_reg);
        wx = STEP_W'(win_x_reg);
        wy = STEP_W'(win_y_reg);
        nx = sx;
        ny = sy;
        rightward_next = rightward_reg;
        if (rightward_reg)
        begin
            nx = sx + STEP_W'(1);
            if (nx >= wx + span_x)
            begin
                rightward_next = 1'b0;
                ny = sy + STEP_W'(1);
            end
        end
        else
        begin
            if (sx != '0)
            begin
                nx = sx - STEP_W'(1);
            end
            if (nx <= wx)
            begin
                rightward_next = 1'b1;
                ny = sy + STEP_W'(1);
            end
        end
        if (ny >= wy + span_y)
        begin
            ny = wy;
        end
    end

    assign in_image_next = (nx < STEP_W'(IMAGE_WIDTH)) && (ny < STEP_W'(IMAGE_HEIGHT));
    assign read_lin  = LIN_W'(ny) * LIN_W'(IMAGE_WIDTH) + LIN_W'(nx);
    assign ram_raddr = read_lin[RAM_AW-1:0];
    assign load_lin  = LIN_W'(command.pixel_addr);
    assign ram_waddr = load_lin[RAM_AW-1:0];
    assign ram_we    = accept && (act == xys_pkg::ACT_LOAD) && (load_lin < LIN_W'(DEPTH));

    // scan, window and zoom updates
    always_comb
    begin
        logic [STEP_W-1:0] wx;
        logic [STEP_W-1:0] wy;
        logic              restart;
        wx = STEP_W'(win_x_reg);
        wy = STEP_W'(win_y_reg);
        restart     = 1'b0;
        zoom_next   = zoom_reg;
        win_x_next  = win_x_reg;
        win_y_next  = win_y_reg;
        scan_x_next = scan_x_reg;
        scan_y_next = scan_y_reg;
        if (accept)
        begin
            unique case (act)
                xys_pkg::ACT_TICK:
                begin
                    scan_x_next = nx[CRD_W-1:0];
                    scan_y_next = ny[CRD_W-1:0];
                end
                xys_pkg::ACT_LOAD:
                begin
                end
                xys_pkg::ACT_ZOOM_IN:
                begin
                    if (zoom_reg < xys_pkg::ZOOM_W'(MAX_ZOOM))
                    begin
                        zoom_next = zoom_reg + xys_pkg::ZOOM_W'(1);
                        restart   = 1'b1;
                    end
                end
                xys_pkg::ACT_ZOOM_OUT:
                begin
                    if (zoom_reg > xys_pkg::ZOOM_W'(1))
                    begin
                        zoom_next = zoom_reg - xys_pkg::ZOOM_W'(1);
                        restart   = 1'b1;
                    end
                end
                xys_pkg::ACT_UP:
                begin
                    if (wy != '0)
                    begin
                        win_y_next = (wy > span_y) ? WIN_W'(wy - span_y) : '0;
                        restart    = 1'b1;
                    end
                end
                xys_pkg::ACT_LEFT:
                begin
                    if (wx != '0)
                    begin
                        win_x_next = (wx > span_x) ? WIN_W'(wx - span_x) : '0;
                        restart    = 1'b1;
                    end
                end
                xys_pkg::ACT_DOWN:
                begin
                    if (wy < STEP_W'(IMAGE_HEIGHT) - span_y)
                    begin
                        win_y_next = WIN_W'(wy + span_y);
                        restart    = 1'b1;
                    end
                end
                xys_pkg::ACT_RIGHT:
                begin
                    if (wx < STEP_W'(IMAGE_WIDTH) - span_x)
                    begin
                        win_x_next = WIN_W'(wx + span_x);
                        restart    = 1'b1;
                    end
                end
            endcase
        end
        if (restart)
        begin
            scan_x_next = CRD_W'(win_x_next);
            scan_y_next = CRD_W'(win_y_next);
        end
    end

    xys_ram #(
        .WIDTH (xys_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (command.pixel_value),
        .re    (tick_acc),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    xys_norm #(.CRD_W(CRD_W), .WIN_W(WIN_W)) u_norm_x (
        .pos    (scan_x_reg),
        .win    (win_x_reg),
        .recip  (recip_x),
        .sample (norm_x)
    );

    xys_norm #(.CRD_W(CRD_W), .WIN_W(WIN_W)) u_norm_y (
        .pos    (scan_y_reg),
        .win    (win_y_reg),
        .recip  (recip_y),
        .sample (norm_y)
    );

    assign pix = in_image_reg ? ram_rdata : '0;

    // held deflection, updated in the update state of a tick
    always_comb
    begin
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (upd_en)
        begin
            if (!present_reg)
            begin
                held_x_next = '0;
                held_y_next = '0;
            end
            else if (pix >= thr_reg)
            begin
                held_x_next = norm_x;
                held_y_next = norm_y;
            end
        end
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        if (tick_acc)
        begin
            out_valid_next = 1'b1;
            out_left_next  = held_x_reg;
            out_right_next = held_y_reg;
        end
        else if (sample.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign sample.valid        = out_valid_reg;
    assign sample.left_sample  = $signed(out_left_reg);
    assign sample.right_sample = $signed(out_right_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xys_pkg::S_IDLE;
            thr_reg       <= xys_pkg::THRESHOLD_RESET;
            present_reg   <= 1'b0;
            scan_x_reg    <= '0;
            scan_y_reg    <= '0;
            rightward_reg <= 1'b1;
            zoom_reg      <= xys_pkg::ZOOM_W'(1);
            win_x_reg     <= '0;
            win_y_reg     <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scan_x_reg <= scan_x_next;
            scan_y_reg <= scan_y_next;
            if (tick_acc)
            begin
                rightward_reg <= rightward_next;
            end
            else if (scan_x_next != scan_x_reg || scan_y_next != scan_y_reg
                     || zoom_next != zoom_reg || win_x_next != win_x_reg
                     || win_y_next != win_y_reg)
            begin
                rightward_reg <= 1'b1;
            end
            zoom_reg      <= zoom_next;
            win_x_reg     <= win_x_next;
            win_y_reg     <= win_y_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    xys_pkg::REG_THRESHOLD:     thr_reg     <= cfg_data;
                    xys_pkg::REG_IMAGE_PRESENT: present_reg <= cfg_data[0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_image_reg  <= in_image_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
    end

endmodule

/* hdl/xys_checker.sv */
// ----------------------------------------------------------------------------
// xys_checker
// Port-level checks on the scanner core, bound to the top level.
// ----------------------------------------------------------------------------
module xys_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [xys_pkg::ACTION_W-1:0]        in_action,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [xys_pkg::SAMPLE_W-1:0] out_left,
    input logic signed [xys_pkg::SAMPLE_W-1:0] out_right
);

    logic in_acc;
    logic is_tick;

    assign in_acc  = in_valid && in_ready;
    assign is_tick = (in_action == xys_pkg::ACT_TICK);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
        else $error("sample word changed while stalled");

    // every tick yields a word
    a_tick_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && is_tick |=> out_valid)
        else $error("tick gave no sample word");

    // command ready drops after an accepted tick
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && is_tick |=> !in_ready)
        else $error("command taken during tick update");

    // only ticks produce words
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !is_tick && !out_valid |=> !out_valid)
        else $error("sample word without a tick");

endmodule

bind xy_scope_image_scanner_core xys_checker u_xys_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (command.valid),
    .in_ready  (command.ready),
    .in_action (command.action),
    .out_valid (sample.valid),
    .out_ready (sample.ready),
    .out_left  (sample.left_sample),
    .out_right (sample.right_sample)
);
